// File: hw/rtl/fltw_pkg.sv
// Shared types, constants and codes for the four-level page table walker.
`default_nettype none

package fltw_pkg;

    // Field widths
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int PA_W    = 52;
    localparam int FRAME_W = 40;
    localparam int IDX_W   = 9;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Input kind codes
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_ENTRY     = 1'b1;

    // Result kind codes
    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_DONE = 1'b1;

    // Walk levels (level of the entry awaited)
    localparam logic [1:0] LEVEL_PT   = 2'd0;
    localparam logic [1:0] LEVEL_PD   = 2'd1;
    localparam logic [1:0] LEVEL_PDPT = 2'd2;
    localparam logic [1:0] LEVEL_PML4 = 2'd3;

    // Entry flag bit positions
    localparam int PRESENT_BIT = 0;
    localparam int SIZE_BIT    = 7;

    // Classified item carried from front to back
    typedef struct packed {
        logic               kind;
        logic [VA_W-1:0]    virt_addr;
        logic               present;
        logic               size;
        logic [FRAME_W-1:0] frame;
    } walk_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  s_*     | s_tvalid / s_tready    | tuser: kind; tdata: virt_addr, entry_data
//  m_*     | m_tvalid / m_tready    | tuser: result_kind, fault; tdata: read_address,
//          |                        |        phys_addr
//  cfg_*   | cfg_wr_en              | cfg_wr_data: table_root
//
// One beat per cycle sustained while the output is not stalled: the back end retires one queued
// item each cycle through a single index select and mask stage into the output register.
// An input beat is held in the queue, then formed by the back end into the output register.
// Reset is asynchronous and active low; it clears the walk state, the root and the queue.
// s_tready falls only when the queue is full; an output stall backs up into the queue.
`default_nettype none

module four_level_page_table_walker
    import fltw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [51:0]   cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,   // [47:0] virt_addr, [111:48] entry_data
    input  wire logic [0:0]    s_tuser,   // [0] kind
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [103:0]       m_tdata,   // [51:0] read_address, [103:52] phys_addr
    output logic [1:0]         m_tuser    // [0] result_kind, [1] fault
);

    walk_item_t      front_item;
    walk_item_t      queue_item;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;
    logic            res_kind;
    logic            res_fault;
    logic [PA_W-1:0] res_raddr;
    logic [PA_W-1:0] res_paddr;

    assign s_tready = !queue_full;

    fltw_front u_front
    (
        .kind       (s_tuser[0]),
        .virt_addr  (s_tdata[VA_W-1:0]),
        .entry_data (s_tdata[VA_W +: ENTRY_W]),
        .item       (front_item)
    );

    fltw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    fltw_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .item_valid       (queue_valid),
        .item             (queue_item),
        .item_pop         (queue_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_result_kind  (res_kind),
        .out_read_address (res_raddr),
        .out_phys_addr    (res_paddr),
        .out_fault        (res_fault)
    );

    assign m_tdata = {res_paddr, res_raddr};
    assign m_tuser = {res_fault, res_kind};

endmodule

`default_nettype wire

// File: hw/rtl/fltw_front.sv
// Front end: decodes an input beat into a classified walk item.
`default_nettype none

module fltw_front
    import fltw_pkg::*;
(
    input  wire logic               kind,
    input  wire logic [VA_W-1:0]    virt_addr,
    input  wire logic [ENTRY_W-1:0] entry_data,
    output walk_item_t              item
);

    // Pull out the flags and the frame number; other entry bits are unused
    always_comb
    begin
        item.kind      = kind;
        item.virt_addr = virt_addr;
        item.present   = entry_data[PRESENT_BIT];
        item.size      = entry_data[SIZE_BIT];
        item.frame     = entry_data[12 +: FRAME_W];
    end

endmodule

`default_nettype wire

// File: hw/rtl/fltw_queue.sv
// Short FIFO of classified items between front and back.
`default_nettype none

module fltw_queue
    import fltw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  walk_item_t      push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output walk_item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    walk_item_t             store_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = store_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fltw_back.sv
// Back end: walk state, result forming and the output register.
`default_nettype none

module fltw_back
    import fltw_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [PA_W-1:0] cfg_wr_data,
    input  wire logic            item_valid,
    input  walk_item_t           item,
    output logic                 item_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 out_result_kind,
    output logic [PA_W-1:0]      out_read_address,
    output logic [PA_W-1:0]      out_phys_addr,
    output logic                 out_fault
);

    logic [PA_W-1:0]    table_root_reg;
    logic               busy_reg, busy_next;
    logic [1:0]         level_reg, level_next;
    logic [VA_W-1:0]    held_va_reg, held_va_next;
    logic [FRAME_W-1:0] base_reg, base_next;

    logic               out_valid_reg, out_valid_next;
    logic               rkind_reg, rkind_next;
    logic [PA_W-1:0]    raddr_reg, raddr_next;
    logic [PA_W-1:0]    paddr_reg, paddr_next;
    logic               fault_reg, fault_next;

    logic               emit;
    logic [IDX_W-1:0]   idx;
    logic [1:0]         idx_level;
    logic [VA_W-1:0]    idx_va;

    assign item_pop = item_valid && (!out_valid_reg || out_ready);

    // Level and address for the next request: top level on translate, one down on descend
    assign idx_level = (item.kind == KIND_TRANSLATE) ? LEVEL_PML4 : level_reg - 2'd1;
    assign idx_va    = (item.kind == KIND_TRANSLATE) ? item.virt_addr : held_va_reg;

    // Table index of the level being requested
    always_comb
    begin
        unique case (idx_level)
            LEVEL_PML4: idx = idx_va[39 +: IDX_W];
            LEVEL_PDPT: idx = idx_va[30 +: IDX_W];
            LEVEL_PD:   idx = idx_va[21 +: IDX_W];
            LEVEL_PT:   idx = idx_va[12 +: IDX_W];
            default:    idx = '0;
        endcase
    end

    // Walk step for the popped item
    always_comb
    begin
        busy_next    = busy_reg;
        level_next   = level_reg;
        held_va_next = held_va_reg;
        base_next    = base_reg;
        emit         = 1'b0;
        rkind_next   = RESULT_READ;
        paddr_next   = '0;
        fault_next   = 1'b0;

        if (item.kind == KIND_TRANSLATE)
        begin
            if (!busy_reg)
            begin
                busy_next    = 1'b1;
                level_next   = LEVEL_PML4;
                held_va_next = item.virt_addr;
                base_next    = table_root_reg[PA_W-1:12];
                emit         = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            emit   = 1'b1;
            priority if (!item.present)
            begin
                busy_next  = 1'b0;
                rkind_next = RESULT_DONE;
                fault_next = 1'b1;
            end
            else if (level_reg == LEVEL_PDPT && item.size)
            begin
                // 1 GiB page
                busy_next  = 1'b0;
                rkind_next = RESULT_DONE;
                paddr_next = {item.frame[FRAME_W-1:18], held_va_reg[29:0]};
            end
            else if (level_reg == LEVEL_PD && item.size)
            begin
                // 2 MiB page
                busy_next  = 1'b0;
                rkind_next = RESULT_DONE;
                paddr_next = {item.frame[FRAME_W-1:9], held_va_reg[20:0]};
            end
            else if (level_reg == LEVEL_PT)
            begin
                // 4 KiB page
                busy_next  = 1'b0;
                rkind_next = RESULT_DONE;
                paddr_next = {item.frame, held_va_reg[11:0]};
            end
            else
            begin
                // descend one level
                base_next  = item.frame;
                level_next = level_reg - 1'b1;
            end
        end

        raddr_next = (rkind_next == RESULT_READ) ? {base_next, idx, 3'b000} : '0;
    end

    // Output register occupancy
    always_comb
    begin
        if (item_pop)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_root_reg <= '0;
            busy_reg       <= 1'b0;
            level_reg      <= LEVEL_PT;
            held_va_reg    <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_root_reg <= cfg_wr_data;
            end
            if (item_pop)
            begin
                busy_reg    <= busy_next;
                level_reg   <= level_next;
                held_va_reg <= held_va_next;
                base_reg    <= base_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_pop && emit)
        begin
            rkind_reg <= rkind_next;
            raddr_reg <= raddr_next;
            paddr_reg <= paddr_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_result_kind  = rkind_reg;
    assign out_read_address = raddr_reg;
    assign out_phys_addr    = paddr_reg;
    assign out_fault        = fault_reg;

endmodule

`default_nettype wire
